// File: rtl/jse_pkg.sv
// ----------------------------------------------------------------------------
// jse_pkg: shared types, constants and helpers of the Jaccard similarity engine
// Action codes, field widths, controller states, the result record and a
// 64-bit population count.
// ----------------------------------------------------------------------------
`default_nettype none

package jse_pkg;

  localparam int unsigned NUM_ITEMS_DEF = 256;
  localparam int unsigned NUM_SETS_DEF  = 1024;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned ITEM_W   = 8;
  localparam int unsigned SET_W    = 10;
  localparam int unsigned SIM_W    = 17;
  localparam int unsigned CNT_W    = 11;
  localparam int unsigned WORD_W   = 64;
  localparam int unsigned BIT_W    = $clog2(WORD_W);
  localparam int unsigned PCNT_W   = $clog2(WORD_W + 1);

  localparam int unsigned COUNT_MAX = 2047;

  localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD,
    ST_QA,
    ST_QB,
    ST_QL,
    ST_QD,
    ST_QS,
    ST_DIV,
    ST_OUT
  } st_t;

  typedef struct packed {
    logic [SIM_W-1:0] similarity;
    logic [CNT_W-1:0] common_count;
    logic [CNT_W-1:0] union_count;
    logic             union_empty;
  } res_t;

  // Balanced adder tree: pairs, then wider partial sums, six levels deep.
  function automatic logic [PCNT_W-1:0] popcount64(input logic [WORD_W-1:0] w);
    logic [1:0] s2  [32];
    logic [2:0] s4  [16];
    logic [3:0] s8  [8];
    logic [4:0] s16 [4];
    logic [5:0] s32 [2];
    for (int i = 0; i < 32; i++) begin
      s2[i] = {1'b0, w[2*i]} + {1'b0, w[2*i+1]};
    end
    for (int i = 0; i < 16; i++) begin
      s4[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
    end
    for (int i = 0; i < 8; i++) begin
      s8[i] = {1'b0, s4[2*i]} + {1'b0, s4[2*i+1]};
    end
    for (int i = 0; i < 4; i++) begin
      s16[i] = {1'b0, s8[2*i]} + {1'b0, s8[2*i+1]};
    end
    for (int i = 0; i < 2; i++) begin
      s32[i] = {1'b0, s16[2*i]} + {1'b0, s16[2*i+1]};
    end
    return {1'b0, s32[0]} + {1'b0, s32[1]};
  endfunction

endpackage

`default_nettype wire

// File: rtl/jse_in_if.sv
// ----------------------------------------------------------------------------
// jse_in_if: request channel
// Valid/ready channel carrying one add, remove or query beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface jse_in_if;
  import jse_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [ITEM_W-1:0]   item_index;
  logic [SET_W-1:0]    set_index;
  logic [ITEM_W-1:0]   other_item;

  modport source (output valid, action, item_index, set_index, other_item,
                  input ready);
  modport sink   (input valid, action, item_index, set_index, other_item,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/jse_out_if.sv
// ----------------------------------------------------------------------------
// jse_out_if: result channel
// Valid/ready channel carrying one similarity result beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface jse_out_if;
  import jse_pkg::*;

  logic             valid;
  logic             ready;
  logic [SIM_W-1:0] similarity;
  logic [CNT_W-1:0] common_count;
  logic [CNT_W-1:0] union_count;
  logic             union_empty;

  modport source (output valid, similarity, common_count, union_count, union_empty,
                  input ready);
  modport sink   (input valid, similarity, common_count, union_count, union_empty,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/jse_mem.sv
// ----------------------------------------------------------------------------
// jse_mem: membership word store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module jse_mem #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [AW-1:0]             waddr,
  input  wire logic [jse_pkg::WORD_W-1:0] wdata,
  input  wire logic [AW-1:0]             raddr,
  output logic      [jse_pkg::WORD_W-1:0] rdata
);
  import jse_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/jse_div.sv
// ----------------------------------------------------------------------------
// jse_div: Q1.16 ratio divider
// Restoring division of (num << 16) by den, one quotient bit per cycle.
// Requires num <= den.
// ----------------------------------------------------------------------------
`default_nettype none

module jse_div #(
  parameter int unsigned CW = 11
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [CW-1:0]             num,
  input  wire logic [CW-1:0]             den,
  output logic                           done,
  output logic      [jse_pkg::SIM_W-1:0] quot
);
  import jse_pkg::*;

  localparam int unsigned STEP_W = $clog2(SIM_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SIM_W - 1);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [CW:0]       rem_r;
  logic [SIM_W-1:0]  quot_r;
  logic [CW:0]       trial;
  logic              ge;

  // First step weighs the integer bit, later steps shift in a zero.
  always_comb begin
    trial = (step_r == '0) ? rem_r : {rem_r[CW-1:0], 1'b0};
    ge    = (trial >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, num};
    end else if (busy_r) begin
      rem_r  <= ge ? (trial - {1'b0, den}) : trial;
      quot_r <= {quot_r[SIM_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

`default_nettype wire

// File: rtl/jse_ctrl.sv
// ----------------------------------------------------------------------------
// jse_ctrl: request sequencer
// Clears the store after reset, does read-modify-write for add and remove,
// and walks both item rows word by word for a query, accumulating the
// intersection and union bit counts before handing them to the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module jse_ctrl #(
  parameter int unsigned NUM_ITEMS = 256,
  parameter int unsigned NUM_SETS  = 1024,
  parameter int unsigned WPI       = (NUM_SETS + 63) / 64,
  parameter int unsigned DEPTH     = NUM_ITEMS * WPI,
  parameter int unsigned AW        = $clog2(DEPTH),
  parameter int unsigned CW        = $clog2(NUM_SETS + 1)
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_acc,
  output logic                              in_ready,
  input  wire logic [jse_pkg::ACTION_W-1:0] in_action,
  input  wire logic [jse_pkg::ITEM_W-1:0]   in_item,
  input  wire logic [jse_pkg::SET_W-1:0]    in_set,
  input  wire logic [jse_pkg::ITEM_W-1:0]   in_other,
  output logic                              mem_we,
  output logic      [AW-1:0]                mem_waddr,
  output logic      [jse_pkg::WORD_W-1:0]   mem_wdata,
  output logic      [AW-1:0]                mem_raddr,
  input  wire logic [jse_pkg::WORD_W-1:0]   mem_rdata,
  output logic                              div_start,
  output logic      [CW-1:0]                div_num,
  output logic      [CW-1:0]                div_den,
  input  wire logic                         div_done,
  input  wire logic [jse_pkg::SIM_W-1:0]    div_quot,
  output logic                              res_vld,
  input  wire logic                         res_take,
  output jse_pkg::res_t                     res
);
  import jse_pkg::*;

  localparam int unsigned KW = (WPI > 1) ? $clog2(WPI) : 1;
  localparam logic [KW-1:0] K_LAST   = KW'(WPI - 1);
  localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

  st_t               state_r, state_nxt;
  logic [AW-1:0]     clr_r;
  logic [KW-1:0]     k_r;
  logic [ITEM_W-1:0] item_a_r;
  logic [ITEM_W-1:0] item_b_r;
  logic              a_oor_r;
  logic              b_oor_r;
  logic [AW-1:0]     upd_addr_r;
  logic [BIT_W-1:0]  upd_bit_r;
  logic              upd_add_r;
  logic [WORD_W-1:0] a_word_r;
  logic              pc_vld_r;
  logic [WORD_W-1:0] and_r;
  logic [WORD_W-1:0] or_r;
  logic [CW-1:0]     common_r;
  logic [CW-1:0]     union_r;

  logic              upd_ok;
  logic              b_arrives;
  logic [WORD_W-1:0] a_word;
  logic [WORD_W-1:0] b_word;
  logic [WORD_W-1:0] bit_mask;
  logic              empty;

  function automatic logic [AW-1:0] row_addr(input logic [ITEM_W-1:0] item,
                                             input logic [31:0] word);
    logic [31:0] a;
    a = 32'(item) * 32'(WPI) + word;
    return a[AW-1:0];
  endfunction

  assign upd_ok    = (32'(in_item) < NUM_ITEMS) && (32'(in_set) < NUM_SETS);
  // The B word of the previous index is on the read data here.
  assign b_arrives = ((state_r == ST_QA) && (k_r != '0)) || (state_r == ST_QL);
  assign a_word    = a_oor_r ? '0 : mem_rdata;
  assign b_word    = b_oor_r ? '0 : mem_rdata;
  assign bit_mask  = WORD_W'(1) << upd_bit_r;
  assign empty     = (union_r == '0);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_r == CLR_LAST) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          if ((in_action == ACT_ADD || in_action == ACT_REMOVE) && upd_ok) begin
            state_nxt = ST_UPD;
          end else if (in_action == ACT_QUERY) begin
            state_nxt = ST_QA;
          end
        end
      end
      ST_UPD:  state_nxt = ST_IDLE;
      ST_QA:   state_nxt = ST_QB;
      ST_QB:   state_nxt = (k_r == K_LAST) ? ST_QL : ST_QA;
      ST_QL:   state_nxt = ST_QD;
      ST_QD:   state_nxt = ST_QS;
      ST_QS:   state_nxt = ST_DIV;
      ST_DIV:  if (div_done) state_nxt = ST_OUT;
      ST_OUT:  if (res_take) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = upd_addr_r;
    mem_wdata = '0;
    mem_raddr = row_addr(in_item, 32'(in_set[SET_W-1:BIT_W]));
    div_start = 1'b0;
    res_vld   = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
      end
      ST_IDLE: in_ready = 1'b1;
      ST_UPD: begin
        mem_we    = 1'b1;
        mem_wdata = upd_add_r ? (mem_rdata | bit_mask) : (mem_rdata & ~bit_mask);
      end
      ST_QA:   mem_raddr = row_addr(item_a_r, 32'(k_r));
      ST_QB:   mem_raddr = row_addr(item_b_r, 32'(k_r));
      ST_QS:   div_start = 1'b1;
      ST_OUT:  res_vld   = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      clr_r    <= '0;
      pc_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pc_vld_r <= b_arrives;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_acc) begin
      upd_addr_r <= mem_raddr;
      upd_bit_r  <= in_set[BIT_W-1:0];
      upd_add_r  <= (in_action == ACT_ADD);
      item_a_r   <= in_item;
      item_b_r   <= in_other;
      a_oor_r    <= !(32'(in_item) < NUM_ITEMS);
      b_oor_r    <= !(32'(in_other) < NUM_ITEMS);
      k_r        <= '0;
      common_r   <= '0;
      union_r    <= '0;
    end else begin
      if (state_r == ST_QB) begin
        a_word_r <= a_word;
        k_r      <= k_r + 1'b1;
      end
      if (pc_vld_r) begin
        common_r <= common_r + CW'(popcount64(and_r));
        union_r  <= union_r + CW'(popcount64(or_r));
      end
    end
    if (b_arrives) begin
      and_r <= a_word_r & b_word;
      or_r  <= a_word_r | b_word;
    end
  end

  assign div_num = common_r;
  assign div_den = union_r;

  always_comb begin
    res.similarity   = empty ? '0 : div_quot;
    res.common_count = (32'(common_r) > COUNT_MAX) ? CNT_W'(COUNT_MAX) : CNT_W'(common_r);
    res.union_count  = (32'(union_r) > COUNT_MAX) ? CNT_W'(COUNT_MAX) : CNT_W'(union_r);
    res.union_empty  = empty;
  end

endmodule

`default_nettype wire

// File: rtl/jaccard_similarity_engine.sv
// ----------------------------------------------------------------------------
// jaccard_similarity_engine: Jaccard similarity over item membership bitmaps
// Add/remove beats set or clear one (item, set) bit; a query beat returns the
// intersection and union counts of two items and their ratio in Q1.16.
// ----------------------------------------------------------------------------
// After reset the block sweeps the membership store to zero, one 64-bit word
// per cycle, NUM_ITEMS * ceil(NUM_SETS/64) words (4096 at the defaults), with
// ready low. It then handles one beat at a time. An add or remove is a
// read-modify-write of one store word. A query reads the two rows word by
// word through the single read port, two reads per word, then runs a
// bit-serial divider. The finished result sits in an output register, so the
// next beat is taken while it waits on the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module jaccard_similarity_engine #(
  parameter int unsigned NUM_ITEMS = jse_pkg::NUM_ITEMS_DEF,
  parameter int unsigned NUM_SETS  = jse_pkg::NUM_SETS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  jse_in_if.sink     in_ch,
  jse_out_if.source  out_ch
);
  import jse_pkg::*;

  localparam int unsigned WPI   = (NUM_SETS + 63) / 64;
  localparam int unsigned DEPTH = NUM_ITEMS * WPI;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(NUM_SETS + 1);

  logic              in_acc;
  logic              in_ready;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [WORD_W-1:0] mem_rdata;
  logic              div_start;
  logic [CW-1:0]     div_num;
  logic [CW-1:0]     div_den;
  logic              div_done;
  logic [SIM_W-1:0]  div_quot;
  logic              res_vld;
  logic              res_take;
  res_t              res;
  logic              out_vld_r;
  res_t              out_r;

  assign in_acc      = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  jse_ctrl #(
    .NUM_ITEMS (NUM_ITEMS),
    .NUM_SETS  (NUM_SETS),
    .WPI       (WPI),
    .DEPTH     (DEPTH),
    .AW        (AW),
    .CW        (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_acc    (in_acc),
    .in_ready  (in_ready),
    .in_action (in_ch.action),
    .in_item   (in_ch.item_index),
    .in_set    (in_ch.set_index),
    .in_other  (in_ch.other_item),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .div_start (div_start),
    .div_num   (div_num),
    .div_den   (div_den),
    .div_done  (div_done),
    .div_quot  (div_quot),
    .res_vld   (res_vld),
    .res_take  (res_take),
    .res       (res)
  );

  jse_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  jse_div #(
    .CW (CW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Load the output register with a waiting result whenever it is empty or being drained.
  assign res_take = res_vld && (!out_vld_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_take) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= res;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.similarity   = out_r.similarity;
  assign out_ch.common_count = out_r.common_count;
  assign out_ch.union_count  = out_r.union_count;
  assign out_ch.union_empty  = out_r.union_empty;

  a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld || div_start || mem_we) |-> !in_ready)
    else $error("request taken while a beat is still in flight");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.union_empty) |->
      (out_r.similarity == '0 && out_r.union_count == '0 && out_r.common_count == '0))
    else $error("empty union with nonzero result fields");

  a_common_le_union: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_r.common_count <= out_r.union_count))
    else $error("intersection count exceeds union count");

  a_sim_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_r.similarity <= SIM_W'(65536)))
    else $error("similarity above 1.0");

  a_div_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> !div_done)
    else $error("divider done right after start");

endmodule

`default_nettype wire
